// File: rtl/lsbs_pkg.sv
package lsbs_pkg;

   // Phase codes
   localparam logic [1:0] PH_ACQ    = 2'd0;
   localparam logic [1:0] PH_SERVE  = 2'd1;
   localparam logic [1:0] PH_LISTEN = 2'd2;

   // Event codes
   localparam logic [2:0] OP_TICK   = 3'd0;
   localparam logic [2:0] OP_HEARD  = 3'd1;
   localparam logic [2:0] OP_MFIX   = 3'd2;
   localparam logic [2:0] OP_OFIX   = 3'd3;
   localparam logic [2:0] OP_LISTEN = 3'd4;
   localparam logic [2:0] OP_SERVE  = 3'd5;
   localparam logic [2:0] OP_SEED   = 3'd6;

   // Register indexes
   localparam logic [2:0] REG_ACQ_TIMEOUT = 3'd0;
   localparam logic [2:0] REG_LIS_INTVL   = 3'd1;
   localparam logic [2:0] REG_LIS_DUR     = 3'd2;
   localparam logic [2:0] REG_DWELL       = 3'd3;
   localparam logic [2:0] REG_EXPLORE     = 3'd4;
   localparam logic [2:0] REG_EXIT_FIX    = 3'd5;
   localparam logic [2:0] REG_BAND_COUNT  = 3'd6;
   localparam logic [2:0] REG_KHZ_TABLE   = 3'd7;

   // Register reset values
   localparam logic [39:0] RST_ACQ_TIMEOUT = 40'd900000000;
   localparam logic [39:0] RST_LIS_INTVL   = 40'd3600000000;
   localparam logic [39:0] RST_LIS_DUR     = 40'd180000000;
   localparam logic [39:0] RST_DWELL       = 40'd120000000;
   localparam logic [7:0]  RST_EXPLORE     = 8'd4;
   localparam logic [2:0]  RST_BAND_COUNT  = 3'd3;
   localparam logic [63:0] RST_KHZ_TABLE   = {16'd0, 16'd15000, 16'd10000, 16'd5000};

   localparam logic [39:0] MASK40   = 40'hFF_FFFF_FFFF;
   localparam logic [31:0] SAT32    = 32'hFFFF_FFFF;
   localparam logic [15:0] SAT16    = 16'hFFFF;

   localparam int DEF_MAX_BANDS  = 4;
   localparam int DEF_UTC_BLOCKS = 4;

   // Band frequency from the packed table; bands beyond the table read 0
   function automatic logic [15:0] khz_of(input logic [63:0] tab, input int idx);
      logic [15:0] r;
      case (idx)
         0: r = tab[15:0];
         1: r = tab[31:16];
         2: r = tab[47:32];
         3: r = tab[63:48];
         default: r = 16'd0;
      endcase
      return r;
   endfunction

endpackage

// File: rtl/listen_serve_band_scheduler.sv
// Listen/serve band scheduler. Each request transaction carries one timestamped
// event and yields exactly one response transaction with the phase directive
// and the time left until the phase is due to end. Per-band success counts and
// per-band, per-UTC-block counts live in two on-chip memories (registered read);
// they read as zero from reset with no clearing pass. A seed event that matches
// a band writes its block counts, up to four, one after another. A tick that
// opens a listen window runs a credit scan through the memories, reading and
// comparing each band in rotation, and, when probing is enabled, a bit-serial
// modulo of the 32-bit window count. The next request can be taken in the same
// cycle as the response is offered. One event is in flight at a time; a new
// request is taken while the previous response still waits, and that event then
// holds in its output state until the earlier response has gone. Register writes
// are taken only while no event is in flight.
module listen_serve_band_scheduler #(
   parameter int MAX_BANDS  = lsbs_pkg::DEF_MAX_BANDS,
   parameter int UTC_BLOCKS = lsbs_pkg::DEF_UTC_BLOCKS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [2:0]        req_op,
   input  logic [62:0]       req_time_us,
   input  logic signed [2:0] req_utc_block,
   input  logic [15:0]       req_seed_khz,
   input  logic [31:0]       req_seed_successes,
   input  logic [15:0]       req_seed_block_0,
   input  logic [15:0]       req_seed_block_1,
   input  logic [15:0]       req_seed_block_2,
   input  logic [15:0]       req_seed_block_3,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [1:0]        rsp_phase,
   output logic              rsp_wifi_up,
   output logic              rsp_marker_listening,
   output logic              rsp_rds_active,
   output logic [15:0]       rsp_listen_band_khz,
   output logic              rsp_seed_matched,
   output logic [39:0]       rsp_until_change_us,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [2:0]        csr_index,
   input  logic [63:0]       csr_data
);

   localparam int CUR_W  = (MAX_BANDS > 1) ? $clog2(MAX_BANDS) : 1;
   localparam int BC_W   = $clog2(MAX_BANDS + 1);
   localparam int BLK_D  = MAX_BANDS * UTC_BLOCKS;
   localparam int BLK_AW = (BLK_D > 1) ? $clog2(BLK_D) : 1;
   localparam int NSEED  = (UTC_BLOCKS < 4) ? UTC_BLOCKS : 4;

   typedef enum logic [3:0] {
      S_IDLE, S_EXEC, S_EXPIRE, S_TICK, S_LSTART, S_SCAN_RD, S_SCAN_CMP,
      S_MOD, S_PICK, S_HEARD, S_SEED, S_DUE, S_OUT
   } state_type;

   state_type state_ff;

   // Latched transaction
   logic [2:0]  op_ff;
   logic [62:0] now_ff;
   logic [2:0]  ub_ff;
   logic [15:0] seed_khz_ff;
   logic [31:0] seed_succ_ff;
   logic [15:0] seed_blk_ff [4];

   // Configuration
   logic [39:0]     acq_to_ff, lis_int_ff, lis_dur_ff, dwell_ff;
   logic [7:0]      explore_ff;
   logic            exit_fix_ff;
   logic [BC_W-1:0] band_count_ff;
   logic [63:0]     khz_tab_ff;

   // Scheduler state
   logic             started_ff, fix_seen_ff, listen_req_ff, serve_req_ff;
   logic             band_heard_ff, last_heard_ff;
   logic [1:0]       cur_phase_ff;
   logic [62:0]      acq_start_ff, band_start_ff, listen_start_ff, last_end_ff;
   logic [CUR_W-1:0] cursor_ff;
   logic [31:0]      windows_ff;

   // Working registers
   logic             exp_acq_ff, exp_int_ff, exp_dur_ff, exp_dwell_ff;
   logic [CUR_W-1:0] idx_ff, best_ff, hit_idx_ff;
   logic [31:0]      bestc_ff;
   logic [8:0]       rem_ff;
   logic [4:0]       bit_ff;
   logic [1:0]       k_ff;
   logic             matched_ff;
   logic [63:0]      due_ff;

   // Response registers
   logic        rsp_valid_ff, rsp_wifi_ff, rsp_marker_ff, rsp_matched_ff;
   logic [1:0]  rsp_phase_ff;
   logic [15:0] rsp_khz_ff;
   logic [39:0] rsp_until_ff;

   // Memory ports
   logic              band_we, blk_we;
   logic [CUR_W-1:0]  band_waddr, band_raddr;
   logic [31:0]       band_wdata, band_rdata;
   logic [BLK_AW-1:0] blk_waddr, blk_raddr;
   logic [15:0]       blk_wdata, blk_rdata;

   logic             blk_ok;
   logic             seed_hit;
   logic [CUR_W-1:0] seed_idx;
   logic [31:0]      credit;
   logic [8:0]       rem_sh;
   logic [8:0]       rem_nx;

   function automatic logic expired(input logic [62:0] now, input logic [62:0] since,
                                    input logic [39:0] dur);
      logic [62:0] d;
      d = now - since;
      return (now >= since) && (d >= {23'd0, dur});
   endfunction

   function automatic logic [CUR_W-1:0] next_band(input logic [CUR_W-1:0] i,
                                                   input logic [BC_W-1:0] bc);
      logic [BC_W:0] n;
      n = (BC_W+1)'(i) + 1'b1;
      return (n >= {1'b0, bc}) ? '0 : CUR_W'(n);
   endfunction

   function automatic logic [BLK_AW-1:0] blk_addr(input logic [CUR_W-1:0] b,
                                                   input logic [1:0] k);
      return BLK_AW'(32'(b) * UTC_BLOCKS + 32'(k));
   endfunction

   assign blk_ok = !ub_ff[2] && (32'(ub_ff[1:0]) < UTC_BLOCKS);

   // First band whose frequency matches the seed
   always_comb begin
      seed_hit = 1'b0;
      seed_idx = '0;
      for (int i = MAX_BANDS - 1; i >= 0; i--) begin
         if ((i < 32'(band_count_ff)) && (lsbs_pkg::khz_of(khz_tab_ff, i) == seed_khz_ff)) begin
            seed_hit = 1'b1;
            seed_idx = CUR_W'(i);
         end
      end
   end

   // Memory address and write selection
   always_comb begin
      band_raddr = (state_ff == S_SCAN_RD) ? idx_ff : cursor_ff;
      blk_raddr  = blk_addr(band_raddr, ub_ff[1:0]);
      band_we    = ((state_ff == S_EXEC) && (op_ff == lsbs_pkg::OP_SEED) && seed_hit) ||
                   (state_ff == S_HEARD);
      band_waddr = (state_ff == S_HEARD) ? cursor_ff : seed_idx;
      band_wdata = (state_ff == S_HEARD) ?
                   ((band_rdata == lsbs_pkg::SAT32) ? band_rdata : band_rdata + 32'd1) :
                   seed_succ_ff;
      blk_we     = ((state_ff == S_HEARD) && blk_ok) || (state_ff == S_SEED);
      blk_waddr  = (state_ff == S_HEARD) ? blk_addr(cursor_ff, ub_ff[1:0]) :
                                           blk_addr(hit_idx_ff, k_ff);
      blk_wdata  = (state_ff == S_HEARD) ?
                   ((blk_rdata == lsbs_pkg::SAT16) ? blk_rdata : blk_rdata + 16'd1) :
                   seed_blk_ff[k_ff];
   end

   lsbs_ram #(.WIDTH(32), .DEPTH(MAX_BANDS), .AW(CUR_W)) u_band_ram (
      .clock(clock), .reset(reset),
      .wr_en(band_we), .wr_addr(band_waddr), .wr_data(band_wdata),
      .rd_addr(band_raddr), .rd_data(band_rdata)
   );

   lsbs_ram #(.WIDTH(16), .DEPTH(BLK_D), .AW(BLK_AW)) u_block_ram (
      .clock(clock), .reset(reset),
      .wr_en(blk_we), .wr_addr(blk_waddr), .wr_data(blk_wdata),
      .rd_addr(blk_raddr), .rd_data(blk_rdata)
   );

   // Credit and modulo step
   assign credit = blk_ok ? {16'd0, blk_rdata} : band_rdata;
   assign rem_sh = {rem_ff[7:0], windows_ff[bit_ff]};
   assign rem_nx = (rem_sh >= {1'b0, explore_ff}) ? rem_sh - {1'b0, explore_ff} : rem_sh;

   // Sequencer, scheduler state and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         acq_to_ff     <= lsbs_pkg::RST_ACQ_TIMEOUT;
         lis_int_ff    <= lsbs_pkg::RST_LIS_INTVL;
         lis_dur_ff    <= lsbs_pkg::RST_LIS_DUR;
         dwell_ff      <= lsbs_pkg::RST_DWELL;
         explore_ff    <= lsbs_pkg::RST_EXPLORE;
         exit_fix_ff   <= 1'b1;
         band_count_ff <= (32'(lsbs_pkg::RST_BAND_COUNT) > MAX_BANDS) ?
                          BC_W'(MAX_BANDS) : BC_W'(lsbs_pkg::RST_BAND_COUNT);
         khz_tab_ff    <= lsbs_pkg::RST_KHZ_TABLE;
         started_ff    <= 1'b0;
         fix_seen_ff   <= 1'b0;
         listen_req_ff <= 1'b0;
         serve_req_ff  <= 1'b0;
         band_heard_ff <= 1'b0;
         last_heard_ff <= 1'b0;
         cur_phase_ff  <= lsbs_pkg::PH_ACQ;
         acq_start_ff  <= '0;
         band_start_ff <= '0;
         listen_start_ff <= '0;
         last_end_ff   <= '0;
         cursor_ff     <= '0;
         windows_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end

         // Configuration writes, taken only between events
         if (csr_valid && csr_ready) begin
            case (csr_index)
               lsbs_pkg::REG_ACQ_TIMEOUT: acq_to_ff  <= csr_data[39:0];
               lsbs_pkg::REG_LIS_INTVL:   lis_int_ff <= csr_data[39:0];
               lsbs_pkg::REG_LIS_DUR:     lis_dur_ff <= csr_data[39:0];
               lsbs_pkg::REG_DWELL:       dwell_ff   <= csr_data[39:0];
               lsbs_pkg::REG_EXPLORE:     explore_ff <= csr_data[7:0];
               lsbs_pkg::REG_EXIT_FIX:    exit_fix_ff <= csr_data[0];
               lsbs_pkg::REG_BAND_COUNT: begin
                  if (csr_data[2:0] == 3'd0) begin
                     band_count_ff <= BC_W'(1);
                  end else if (32'(csr_data[2:0]) > MAX_BANDS) begin
                     band_count_ff <= BC_W'(MAX_BANDS);
                  end else begin
                     band_count_ff <= BC_W'(csr_data[2:0]);
                  end
                  cursor_ff <= '0;
               end
               lsbs_pkg::REG_KHZ_TABLE:   khz_tab_ff <= csr_data;
               default: ;
            endcase
         end

         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  op_ff          <= req_op;
                  now_ff         <= req_time_us;
                  ub_ff          <= req_utc_block;
                  seed_khz_ff    <= req_seed_khz;
                  seed_succ_ff   <= req_seed_successes;
                  seed_blk_ff[0] <= req_seed_block_0;
                  seed_blk_ff[1] <= req_seed_block_1;
                  seed_blk_ff[2] <= req_seed_block_2;
                  seed_blk_ff[3] <= req_seed_block_3;
                  matched_ff     <= 1'b0;
                  state_ff       <= S_EXEC;
               end
            end

            S_EXEC: begin
               state_ff <= S_DUE;
               case (op_ff)
                  lsbs_pkg::OP_TICK: begin
                     // first tick starts the block
                     if (!started_ff) begin
                        started_ff    <= 1'b1;
                        cur_phase_ff  <= lsbs_pkg::PH_ACQ;
                        acq_start_ff  <= now_ff;
                        band_start_ff <= now_ff;
                        cursor_ff     <= '0;
                        fix_seen_ff   <= 1'b0;
                        listen_req_ff <= 1'b0;
                        serve_req_ff  <= 1'b0;
                        band_heard_ff <= 1'b0;
                     end
                     state_ff <= S_EXPIRE;
                  end
                  lsbs_pkg::OP_HEARD: begin
                     band_heard_ff <= 1'b1;
                     state_ff      <= S_HEARD;
                  end
                  lsbs_pkg::OP_MFIX: begin
                     fix_seen_ff <= 1'b1;
                     if ((cur_phase_ff == lsbs_pkg::PH_LISTEN) && exit_fix_ff) begin
                        last_heard_ff <= band_heard_ff;
                        if (!band_heard_ff) begin
                           cursor_ff <= next_band(cursor_ff, band_count_ff);
                        end
                        cur_phase_ff  <= lsbs_pkg::PH_SERVE;
                        last_end_ff   <= now_ff;
                        listen_req_ff <= 1'b0;
                        serve_req_ff  <= 1'b0;
                     end
                  end
                  lsbs_pkg::OP_OFIX:   fix_seen_ff   <= 1'b1;
                  lsbs_pkg::OP_LISTEN: listen_req_ff <= 1'b1;
                  lsbs_pkg::OP_SERVE:  serve_req_ff  <= 1'b1;
                  lsbs_pkg::OP_SEED: begin
                     // band success count written this cycle through band_we
                     matched_ff <= seed_hit;
                     hit_idx_ff <= seed_idx;
                     k_ff       <= '0;
                     if (seed_hit) begin
                        state_ff <= S_SEED;
                     end
                  end
                  default: ;
               endcase
            end

            S_EXPIRE: begin
               exp_acq_ff   <= expired(now_ff, acq_start_ff, acq_to_ff);
               exp_int_ff   <= expired(now_ff, last_end_ff, lis_int_ff);
               exp_dur_ff   <= expired(now_ff, listen_start_ff, lis_dur_ff);
               exp_dwell_ff <= expired(now_ff, band_start_ff, dwell_ff);
               state_ff     <= S_TICK;
            end

            S_TICK: begin
               state_ff <= S_DUE;
               case (cur_phase_ff)
                  lsbs_pkg::PH_ACQ: begin
                     if (listen_req_ff) begin
                        cur_phase_ff <= lsbs_pkg::PH_SERVE;
                        last_end_ff  <= now_ff;
                        state_ff     <= S_LSTART;
                     end else if (fix_seen_ff || serve_req_ff || exp_acq_ff) begin
                        cur_phase_ff  <= lsbs_pkg::PH_SERVE;
                        last_end_ff   <= now_ff;
                        listen_req_ff <= 1'b0;
                        serve_req_ff  <= 1'b0;
                     end else if (!band_heard_ff && exp_dwell_ff) begin
                        cursor_ff     <= next_band(cursor_ff, band_count_ff);
                        band_start_ff <= now_ff;
                     end
                  end
                  lsbs_pkg::PH_SERVE: begin
                     if (listen_req_ff || exp_int_ff) begin
                        state_ff <= S_LSTART;
                     end
                  end
                  default: begin
                     if (serve_req_ff || exp_dur_ff) begin
                        last_heard_ff <= band_heard_ff;
                        if (!band_heard_ff) begin
                           cursor_ff <= next_band(cursor_ff, band_count_ff);
                        end
                        cur_phase_ff  <= lsbs_pkg::PH_SERVE;
                        last_end_ff   <= now_ff;
                        listen_req_ff <= 1'b0;
                        serve_req_ff  <= 1'b0;
                     end else if (!band_heard_ff && exp_dwell_ff) begin
                        cursor_ff     <= next_band(cursor_ff, band_count_ff);
                        band_start_ff <= now_ff;
                     end
                  end
               endcase
            end

            // Open a listen window
            S_LSTART: begin
               cur_phase_ff    <= lsbs_pkg::PH_LISTEN;
               listen_start_ff <= now_ff;
               band_start_ff   <= now_ff;
               windows_ff      <= windows_ff + 32'd1;
               listen_req_ff   <= 1'b0;
               serve_req_ff    <= 1'b0;
               band_heard_ff   <= 1'b0;
               idx_ff          <= '0;
               best_ff         <= '0;
               bestc_ff        <= '0;
               rem_ff          <= '0;
               bit_ff          <= 5'd31;
               state_ff        <= S_SCAN_RD;
            end

            S_SCAN_RD: state_ff <= S_SCAN_CMP;

            // Highest credit, first band wins ties
            S_SCAN_CMP: begin
               if ((idx_ff == '0) || (credit > bestc_ff)) begin
                  bestc_ff <= credit;
                  best_ff  <= idx_ff;
               end
               if ((BC_W+1)'(idx_ff) + 1'b1 >= {1'b0, band_count_ff}) begin
                  state_ff <= (explore_ff == 8'd0) ? S_PICK : S_MOD;
               end else begin
                  idx_ff   <= idx_ff + 1'b1;
                  state_ff <= S_SCAN_RD;
               end
            end

            // Window count modulo the probe period, one bit per cycle
            S_MOD: begin
               rem_ff <= rem_nx;
               bit_ff <= bit_ff - 5'd1;
               if (bit_ff == 5'd0) begin
                  state_ff <= S_PICK;
               end
            end

            S_PICK: begin
               if (bestc_ff != 32'd0) begin
                  if ((explore_ff != 8'd0) && (band_count_ff > BC_W'(1)) && (rem_ff == 9'd0)) begin
                     cursor_ff <= next_band(best_ff, band_count_ff);
                  end else if (last_heard_ff) begin
                     cursor_ff <= best_ff;
                  end
               end
               state_ff <= S_DUE;
            end

            S_HEARD: state_ff <= S_DUE;

            S_SEED: begin
               k_ff <= k_ff + 2'd1;
               if (k_ff == 2'(NSEED - 1)) begin
                  state_ff <= S_DUE;
               end
            end

            S_DUE: begin
               case (cur_phase_ff)
                  lsbs_pkg::PH_ACQ:
                     due_ff <= {1'b0, acq_start_ff} + {24'd0, acq_to_ff};
                  lsbs_pkg::PH_SERVE:
                     due_ff <= {1'b0, last_end_ff} + {24'd0, lis_int_ff};
                  default:
                     due_ff <= {1'b0, listen_start_ff} + {24'd0, lis_dur_ff};
               endcase
               state_ff <= S_OUT;
            end

            S_OUT: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff   <= 1'b1;
                  rsp_phase_ff   <= cur_phase_ff;
                  rsp_wifi_ff    <= (cur_phase_ff == lsbs_pkg::PH_SERVE);
                  rsp_marker_ff  <= (cur_phase_ff != lsbs_pkg::PH_SERVE);
                  rsp_khz_ff     <= (cur_phase_ff != lsbs_pkg::PH_SERVE) ?
                                    lsbs_pkg::khz_of(khz_tab_ff, 32'(cursor_ff)) : 16'd0;
                  rsp_matched_ff <= matched_ff;
                  if (due_ff <= {1'b0, now_ff}) begin
                     rsp_until_ff <= 40'd0;
                  end else if ((due_ff - {1'b0, now_ff}) > {24'd0, lsbs_pkg::MASK40}) begin
                     rsp_until_ff <= lsbs_pkg::MASK40;
                  end else begin
                     rsp_until_ff <= 40'(due_ff - {1'b0, now_ff});
                  end
                  state_ff <= S_IDLE;
               end
            end

            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_ready            = (state_ff == S_IDLE);
   assign csr_ready            = (state_ff == S_IDLE);
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_phase            = rsp_phase_ff;
   assign rsp_wifi_up          = rsp_wifi_ff;
   assign rsp_marker_listening = rsp_marker_ff;
   assign rsp_rds_active       = 1'b1;
   assign rsp_listen_band_khz  = rsp_khz_ff;
   assign rsp_seed_matched     = rsp_matched_ff;
   assign rsp_until_change_us  = rsp_until_ff;

   // The cursor always points at a band in rotation
   a_cursor_in_range: assert property (@(posedge clock) disable iff (reset)
      (BC_W+1)'(cursor_ff) < {1'b0, band_count_ff})
      else $error("band cursor beyond band count");

   // One event at a time: no request taken in the cycle after one is taken
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while an event is in progress");

   // Probing bits are only counted when probing is enabled
   a_mod_enabled: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MOD) |-> (explore_ff != 8'd0))
      else $error("modulo run with probing disabled");

endmodule

// File: rtl/lsbs_ram.sv
// Single-port-write, single-port-read memory with registered read data.
// Entries read as zero until first written (per-entry valid bits).
module lsbs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [DEPTH-1:0] valid_ff;
   logic [WIDTH-1:0] rd_data_ff;

   // Storage
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Valid bits, cleared together at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   // Registered read
   always_ff @(posedge clock) begin
      rd_data_ff <= valid_ff[rd_addr] ? mem[rd_addr] : '0;
   end

   assign rd_data = rd_data_ff;

endmodule

// File: tb/listen_serve_band_scheduler_checker.sv
`timescale 1ns / 100ps

module listen_serve_band_scheduler_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  logic [2:0]        req_op,
   input  logic [62:0]       req_time_us,
   input  logic signed [2:0] req_utc_block,
   input  logic [15:0]       req_seed_khz,
   input  logic [31:0]       req_seed_successes,
   input  logic [15:0]       req_seed_block_0,
   input  logic [15:0]       req_seed_block_1,
   input  logic [15:0]       req_seed_block_2,
   input  logic [15:0]       req_seed_block_3,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  logic [1:0]        rsp_phase,
   input  logic              rsp_wifi_up,
   input  logic              rsp_marker_listening,
   input  logic              rsp_rds_active,
   input  logic [15:0]       rsp_listen_band_khz,
   input  logic              rsp_seed_matched,
   input  logic [39:0]       rsp_until_change_us,
   input  logic              csr_valid,
   input  logic              csr_ready,
   input  logic [2:0]        csr_index,
   input  logic [63:0]       csr_data,
   output int                fail_count,
   output int                pending_count
);

   localparam int NB = lsbs_pkg::DEF_MAX_BANDS;
   localparam int NU = lsbs_pkg::DEF_UTC_BLOCKS;

   typedef struct packed {
      logic [1:0]  phase;
      logic        wifi_up;
      logic        marker;
      logic        rds;
      logic [15:0] khz;
      logic        matched;
      logic [39:0] left;
   } directive_type;

   directive_type directive_q[$];

   // Shadow registers
   logic [39:0] acq_to, lis_int, lis_dur, dwell;
   logic [7:0]  explore;
   logic        exit_fix;
   int          nbands;
   logic [63:0] khz_tab;

   // Shadow scheduler state
   logic        started, fix_seen, lis_req, srv_req, heard, last_heard;
   logic [1:0]  ph;
   int          cursor;
   logic [31:0] windows;
   logic [62:0] acq_start, band_start, lis_start, lis_end;
   logic [31:0] band_ok[NB];
   logic [15:0] blk_ok[NB*NU];
   int          cur_blk;

   function automatic logic timed_out(logic [62:0] now, logic [62:0] since, logic [39:0] dur);
      return now >= since && (now - since) >= {23'd0, dur};
   endfunction

   function automatic logic [15:0] band_khz(int i);
      return (i >= 4) ? 16'd0 : khz_tab[16*i +: 16];
   endfunction

   function automatic int following(int i);
      return (i + 1) % nbands;
   endfunction

   function automatic logic [31:0] band_credit(int i);
      return (cur_blk >= 0) ? {16'd0, blk_ok[i*NU + cur_blk]} : band_ok[i];
   endfunction

   task automatic dwell_step(logic [62:0] now);
      if (!heard && timed_out(now, band_start, dwell)) begin
         cursor = following(cursor);
         band_start = now;
      end
   endtask

   task automatic enter_serving(logic [62:0] now);
      if (ph == lsbs_pkg::PH_LISTEN) begin
         last_heard = heard;
         if (!heard) cursor = following(cursor);
      end
      ph = lsbs_pkg::PH_SERVE;
      lis_end = now;
      lis_req = 0;
      srv_req = 0;
   endtask

   task automatic enter_listening(logic [62:0] now);
      int best;
      logic [31:0] bestc, c;
      logic earned, probe;
      best = 0;
      bestc = 0;
      ph = lsbs_pkg::PH_LISTEN;
      lis_start = now;
      band_start = now;
      windows = windows + 1;
      for (int i = 0; i < nbands; i++) begin
         c = band_credit(i);
         if (i == 0 || c > bestc) begin
            bestc = c;
            best = i;
         end
      end
      earned = bestc > 0;
      probe = explore != 0 && nbands > 1 && (windows % explore) == 0;
      if (earned && probe) cursor = following(best);
      else if (earned && last_heard) cursor = best;
      lis_req = 0;
      srv_req = 0;
      heard = 0;
   endtask

   task automatic on_tick(logic [62:0] now);
      if (!started) begin
         started = 1;
         ph = lsbs_pkg::PH_ACQ;
         acq_start = now;
         band_start = now;
         cursor = 0;
         fix_seen = 0;
         lis_req = 0;
         srv_req = 0;
         heard = 0;
      end
      if (ph == lsbs_pkg::PH_ACQ) begin
         if (lis_req) begin
            enter_serving(now);
            enter_listening(now);
         end else if (fix_seen || srv_req || timed_out(now, acq_start, acq_to)) begin
            enter_serving(now);
         end else begin
            dwell_step(now);
         end
      end else if (ph == lsbs_pkg::PH_SERVE) begin
         if (lis_req || timed_out(now, lis_end, lis_int)) enter_listening(now);
      end else begin
         if (srv_req || timed_out(now, lis_start, lis_dur)) enter_serving(now);
         else dwell_step(now);
      end
   endtask

   // Work out the directive for one accepted event
   task automatic schedule_event();
      directive_type d;
      logic [62:0] now;
      logic [63:0] due, left;
      logic [15:0] seeds[4];
      now = req_time_us;
      cur_blk = (req_utc_block < 0 || req_utc_block >= NU) ? -1 : int'(req_utc_block);
      d.matched = 0;
      seeds = '{req_seed_block_0, req_seed_block_1, req_seed_block_2, req_seed_block_3};
      case (req_op)
         lsbs_pkg::OP_TICK: on_tick(now);
         lsbs_pkg::OP_HEARD: begin
            heard = 1;
            if (band_ok[cursor] != lsbs_pkg::SAT32) band_ok[cursor]++;
            if (cur_blk >= 0 && blk_ok[cursor*NU + cur_blk] != lsbs_pkg::SAT16)
               blk_ok[cursor*NU + cur_blk]++;
         end
         lsbs_pkg::OP_MFIX: begin
            fix_seen = 1;
            if (ph == lsbs_pkg::PH_LISTEN && exit_fix) enter_serving(now);
         end
         lsbs_pkg::OP_OFIX: fix_seen = 1;
         lsbs_pkg::OP_LISTEN: lis_req = 1;
         lsbs_pkg::OP_SERVE: srv_req = 1;
         lsbs_pkg::OP_SEED: begin
            for (int i = 0; i < nbands; i++) begin
               if (!d.matched && band_khz(i) == req_seed_khz) begin
                  band_ok[i] = req_seed_successes;
                  for (int k = 0; k < 4 && k < NU; k++) blk_ok[i*NU + k] = seeds[k];
                  d.matched = 1;
               end
            end
         end
         default: ;
      endcase
      if (ph == lsbs_pkg::PH_ACQ) due = acq_start + acq_to;
      else if (ph == lsbs_pkg::PH_SERVE) due = lis_end + lis_int;
      else due = lis_start + lis_dur;
      left = (due > {1'b0, now}) ? due - now : 64'd0;
      if (left > {24'd0, lsbs_pkg::MASK40}) left = {24'd0, lsbs_pkg::MASK40};
      d.phase = ph;
      d.wifi_up = ph == lsbs_pkg::PH_SERVE;
      d.marker = ph != lsbs_pkg::PH_SERVE;
      d.rds = 1;
      d.khz = d.marker ? band_khz(cursor) : 16'd0;
      d.left = left[39:0];
      directive_q.push_back(d);
   endtask

   task automatic compare(string name, logic [63:0] exp_v, logic [63:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s: expected %0h, actual %0h", name, exp_v, act_v);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      directive_type e;
      if (reset) begin
         acq_to = lsbs_pkg::RST_ACQ_TIMEOUT;
         lis_int = lsbs_pkg::RST_LIS_INTVL;
         lis_dur = lsbs_pkg::RST_LIS_DUR;
         dwell = lsbs_pkg::RST_DWELL;
         explore = lsbs_pkg::RST_EXPLORE;
         exit_fix = 1;
         nbands = lsbs_pkg::RST_BAND_COUNT;
         khz_tab = lsbs_pkg::RST_KHZ_TABLE;
         {started, fix_seen, lis_req, srv_req, heard, last_heard} = '0;
         ph = lsbs_pkg::PH_ACQ;
         cursor = 0;
         windows = 0;
         {acq_start, band_start, lis_start, lis_end} = '0;
         foreach (band_ok[i]) band_ok[i] = 0;
         foreach (blk_ok[i]) blk_ok[i] = 0;
         directive_q.delete();
         fail_count = 0;
      end else begin
         // Register writes
         if (csr_valid && csr_ready) begin
            case (csr_index)
               lsbs_pkg::REG_ACQ_TIMEOUT: acq_to = csr_data[39:0];
               lsbs_pkg::REG_LIS_INTVL: lis_int = csr_data[39:0];
               lsbs_pkg::REG_LIS_DUR: lis_dur = csr_data[39:0];
               lsbs_pkg::REG_DWELL: dwell = csr_data[39:0];
               lsbs_pkg::REG_EXPLORE: explore = csr_data[7:0];
               lsbs_pkg::REG_EXIT_FIX: exit_fix = csr_data[0];
               lsbs_pkg::REG_BAND_COUNT: begin
                  nbands = (csr_data[2:0] < 1) ? 1 : (csr_data[2:0] > NB) ? NB :
                           int'(csr_data[2:0]);
                  cursor = 0;
               end
               lsbs_pkg::REG_KHZ_TABLE: khz_tab = csr_data;
               default: ;
            endcase
         end
         // Response transactions against the oldest directive
         if (rsp_valid && rsp_ready) begin
            if (directive_q.size() == 0) begin
               $error("response transaction with no directive outstanding");
               fail_count++;
            end else begin
               e = directive_q.pop_front();
               compare("phase", e.phase, rsp_phase);
               compare("wifi_up", e.wifi_up, rsp_wifi_up);
               compare("marker_listening", e.marker, rsp_marker_listening);
               compare("rds_active", e.rds, rsp_rds_active);
               compare("listen_band_khz", e.khz, rsp_listen_band_khz);
               compare("seed_matched", e.matched, rsp_seed_matched);
               compare("until_change_us", e.left, rsp_until_change_us);
            end
         end
         if (req_valid && req_ready) schedule_event();
      end
      pending_count = directive_q.size();
   end

endmodule

// File: tb/listen_serve_band_scheduler_test.sv
`timescale 1ns / 100ps

module listen_serve_band_scheduler_test;

   localparam int RANDOM_EVENTS = 1750;
   localparam int STALL_LIMIT   = 5000;

   logic              clock = 0;
   logic              reset = 1;
   logic              req_valid = 0;
   logic              req_ready;
   logic [2:0]        req_op = lsbs_pkg::OP_TICK;
   logic [62:0]       req_time_us = '0;
   logic signed [2:0] req_utc_block = '0;
   logic [15:0]       req_seed_khz = '0;
   logic [31:0]       req_seed_successes = '0;
   logic [15:0]       req_seed_block_0 = '0;
   logic [15:0]       req_seed_block_1 = '0;
   logic [15:0]       req_seed_block_2 = '0;
   logic [15:0]       req_seed_block_3 = '0;
   logic              rsp_valid;
   logic              rsp_ready = 0;
   logic [1:0]        rsp_phase;
   logic              rsp_wifi_up, rsp_marker_listening, rsp_rds_active;
   logic [15:0]       rsp_listen_band_khz;
   logic              rsp_seed_matched;
   logic [39:0]       rsp_until_change_us;
   logic              csr_valid = 0;
   logic              csr_ready;
   logic [2:0]        csr_index = lsbs_pkg::REG_ACQ_TIMEOUT;
   logic [63:0]       csr_data = '0;

   int          fail_count, pending_count;
   int          quiet_cycles;
   logic        calm = 0;
   logic        hold_rsp = 0;
   logic [62:0] clock_us = '0;

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   listen_serve_band_scheduler uut (.*);
   listen_serve_band_scheduler_checker checker_i (.*);

   // Receiver: random stall bursts, a long hold-off on request
   initial begin
      int gap;
      @(posedge clock iff !reset);
      forever begin
         if (hold_rsp) begin
            rsp_ready <= 0;
            repeat (300) @(posedge clock);
            hold_rsp = 0;
         end else if (!calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 8);
            rsp_ready <= 0;
            repeat (gap) @(posedge clock);
         end else begin
            rsp_ready <= 1;
            @(posedge clock);
         end
      end
   end

   // Watchdog over cycles with no transaction on any channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   // Valid stays high across back-to-back writes; the caller drops it
   task automatic write_reg(logic [2:0] idx, logic [63:0] val);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock iff csr_ready);
   endtask

   task automatic wait_idle();
      while (pending_count != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   // Valid stays high after acceptance unless the next call idles first
   task automatic send_event(logic [2:0] op, logic [62:0] t, logic signed [2:0] ub,
                             logic [15:0] khz, logic [31:0] succ);
      int gap;
      if (!calm && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 8);
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_op <= op;
      req_time_us <= t;
      req_utc_block <= ub;
      req_seed_khz <= khz;
      req_seed_successes <= succ;
      req_seed_block_0 <= 16'($urandom);
      req_seed_block_1 <= 16'($urandom);
      req_seed_block_2 <= 16'($urandom);
      req_seed_block_3 <= 16'($urandom);
      @(posedge clock iff req_ready);
   endtask

   // Time moves forward mostly, with the odd step backward
   function automatic logic [62:0] next_time(logic [62:0] t);
      case ($urandom_range(0, 9))
         0: return t - $urandom_range(0, 1000);
         1: return t + 63'({$urandom, $urandom} % 64'd300000);
         default: return t + $urandom_range(0, 40);
      endcase
   endfunction

   task automatic random_phase(int count);
      logic [2:0] op;
      logic [15:0] khz;
      for (int n = 0; n < count; n++) begin
         clock_us = next_time(clock_us);
         op = ($urandom_range(0, 2) == 0) ? 3'($urandom_range(1, 7)) : lsbs_pkg::OP_TICK;
         khz = ($urandom_range(0, 1)) ? 16'($urandom_range(0, 4) * 100) : 16'($urandom);
         send_event(op, clock_us, 3'($urandom), khz,
                    $urandom_range(0, 3) == 0 ? 32'hFFFF_FFFF : $urandom);
      end
      req_valid <= 0;
      wait_idle();
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: events before start, every op, extremes
      send_event(lsbs_pkg::OP_HEARD, 63'd5, -3'sd1, 16'd0, 32'd0);
      send_event(lsbs_pkg::OP_SEED, 63'd5, 3'sd0, 16'd10000, 32'hFFFF_FFFF);
      send_event(lsbs_pkg::OP_SEED, 63'd6, 3'sd0, 16'd1, 32'd1);
      send_event(lsbs_pkg::OP_TICK, 63'd100, 3'sd2, 16'd0, 32'd0);
      send_event(lsbs_pkg::OP_LISTEN, 63'd101, 3'sd3, 16'd0, 32'd0);
      send_event(lsbs_pkg::OP_TICK, 63'd102, 3'sd1, 16'd0, 32'd0);
      send_event(lsbs_pkg::OP_HEARD, 63'd103, 3'sd1, 16'd0, 32'd0);
      send_event(lsbs_pkg::OP_MFIX, 63'd104, 3'sd1, 16'd0, 32'd0);
      send_event(lsbs_pkg::OP_OFIX, 63'd105, -3'sd4, 16'd0, 32'd0);
      send_event(lsbs_pkg::OP_SERVE, 63'd106, 3'sd0, 16'd0, 32'd0);
      send_event(3'd7, 63'd107, 3'sd0, 16'd0, 32'd0);
      send_event(lsbs_pkg::OP_TICK, 63'd50, 3'sd0, 16'd0, 32'd0);
      send_event(lsbs_pkg::OP_TICK, 63'h7FFF_FFFF_FFFF_FFFF, 3'sd0, 16'd0, 32'd0);
      send_event(lsbs_pkg::OP_TICK, 63'd0, 3'sd0, 16'd0, 32'd0);
      req_valid <= 0;
      wait_idle();

      // Several register settings, extremes among them
      for (int s = 0; s < 6; s++) begin
         write_reg(lsbs_pkg::REG_ACQ_TIMEOUT, s == 0 ? 64'd0 :
                   s == 1 ? {24'd0, lsbs_pkg::MASK40} : 64'($urandom_range(0, 2000)));
         write_reg(lsbs_pkg::REG_LIS_INTVL,
                   s == 1 ? 64'hFF_FFFF_FFFF : 64'($urandom_range(0, 3000)));
         write_reg(lsbs_pkg::REG_LIS_DUR, s == 2 ? 64'd0 : 64'($urandom_range(0, 1500)));
         write_reg(lsbs_pkg::REG_DWELL,
                   s == 3 ? 64'hFFFF_FFFF_FFFF_FFFF : 64'($urandom_range(0, 500)));
         write_reg(lsbs_pkg::REG_EXPLORE,
                   s == 0 ? 64'd0 : s == 1 ? 64'hFF : 64'($urandom_range(1, 5)));
         write_reg(lsbs_pkg::REG_EXIT_FIX, 64'(s % 2));
         write_reg(lsbs_pkg::REG_BAND_COUNT,
                   64'(s == 4 ? 0 : s == 5 ? 7 : $urandom_range(1, 4)));
         write_reg(lsbs_pkg::REG_KHZ_TABLE, s == 5 ? {$urandom, $urandom} :
                   {16'd400, 16'd300, 16'd200, 16'($urandom_range(0, 1) * 100)});
         csr_valid <= 0;
         if (s == 2) begin
            // Long receiver hold-off while events keep coming
            hold_rsp = 1;
         end
         if (s == 5) calm = 1;
         random_phase(RANDOM_EVENTS / 6);
      end

      if (fail_count == 0) $display("end of test: clean");
      else $display("end of test: mismatches");
      $finish;
   end

endmodule
